// ===== hdl/sstf_pkg.sv =====
// Shared constants, codes and structs of the shortest-seek-first request scheduler.
// Used by the channel interfaces, the entry queue and the top level.
`default_nettype none

package sstf_pkg;

   localparam int QUEUE_DEPTH    = 16;
   localparam int TRACK_BITS     = 16;
   localparam int MAX_REQUESTERS = 16;

   localparam int REQ_W     = $clog2(MAX_REQUESTERS);
   localparam int IDX_W     = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int CFG_W     = 5;
   localparam int CMP_W     = (CFG_W > COUNT_W) ? CFG_W : COUNT_W;
   localparam int CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_QUEUE_DEPTH = 1'b0,
      CSR_NUM_REQUESTERS  = 1'b1
   } csr_index_type;

   localparam logic RESULT_SERVICED = 1'b0;
   localparam logic RESULT_REJECTED = 1'b1;

   localparam logic [CFG_W-1:0] MAX_DEPTH_RESET = CFG_W'(16);
   localparam logic [CFG_W-1:0] NUM_REQ_RESET   = CFG_W'(16);

   typedef struct packed {
      logic [REQ_W-1:0]      requester;
      logic [TRACK_BITS-1:0] track;
      logic                  last_req;
   } entry_type;

   // top level -> entry queue
   typedef struct packed {
      logic                  insert;
      logic [REQ_W-1:0]      ins_req;
      logic [TRACK_BITS-1:0] ins_track;
      logic                  ins_last;
      logic                  scan_start;
      logic                  retire;
      logic [TRACK_BITS-1:0] head_track;
   } q_cmd_type;

   // entry queue -> top level
   typedef struct packed {
      logic                  dup;
      logic                  slot_found;
      logic [COUNT_W-1:0]    count;
      logic                  scan_done;
      logic                  best_found;
      logic [REQ_W-1:0]      best_requester;
      logic [TRACK_BITS-1:0] best_track;
      logic                  best_last;
   } q_stat_type;

endpackage

`default_nettype wire

// ===== hdl/sstf_req_if.sv =====
// Request channel: valid/ready handshake with one disk request per beat.
// Depends on sstf_pkg for field widths.
`default_nettype none

interface sstf_req_if;
   import sstf_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [REQ_W-1:0]      requester_id;
   logic [TRACK_BITS-1:0] track;
   logic                  final_request;

   modport source (output valid, output requester_id, output track, output final_request,
                   input ready);
   modport sink   (input valid, input requester_id, input track, input final_request,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/sstf_rsp_if.sv =====
// Result channel: valid/ready handshake with one serviced or rejected request per beat.
// Depends on sstf_pkg for field widths.
`default_nettype none

interface sstf_rsp_if;
   import sstf_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  result_kind;
   logic [REQ_W-1:0]      served_requester;
   logic [TRACK_BITS-1:0] served_track;
   logic                  last_of_run;

   modport source (output valid, output result_kind, output served_requester,
                   output served_track, output last_of_run, input ready);
   modport sink   (input valid, input result_kind, input served_requester,
                   input served_track, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hdl/sstf_disk_request_scheduler_core.sv =====
// Shortest-seek-first disk request scheduler, top level: control, head/live state, output.
// Depends on sstf_pkg, sstf_req_if, sstf_rsp_if and sstf_entry_queue.
//
// req_chan carries one disk request per beat (requester, track, final flag).
// rsp_chan returns results: a serviced request (kind 0) or a rejected input
// (kind 1, duplicate requester or full queue). last_of_run marks the last
// result caused by one input; an input that is queued without service gives none.
// csr_we/csr_index/csr_wdata write max_queue_depth (0) and num_requesters (1);
// a num_requesters write also reloads the live count. Write only while idle.
// Timing: an item is evaluated the cycle after its beat; a queued item with no
// service then frees the input, a rejected one does so once the output register
// is free. Each service is a scan of all 16 entries through the single read port
// of the entry memory (pipelined read, distance and compare), then the winner is
// retired and emitted once the output register is free.
// One item is worked on at a time; the next beat is taken when back in idle,
// even while the last result still waits in the output register.
// When rsp_chan stalls, the block holds with the pending result and resumes.
// Reset (synchronous): queue empty, head at track 0, depth and live count 16.
`default_nettype none

module sstf_disk_request_scheduler_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   sstf_req_if.sink                      req_chan,
   sstf_rsp_if.source                    rsp_chan,
   input  wire logic                     csr_we,
   input  wire sstf_pkg::csr_index_type  csr_index,
   input  wire logic [sstf_pkg::CFG_W-1:0] csr_wdata
);
   import sstf_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SCAN,
      ST_SERVE
   } state_type;

   state_type state_ff;

   logic [REQ_W-1:0]      in_req_ff;
   logic [TRACK_BITS-1:0] in_track_ff;
   logic                  in_last_ff;

   logic [CFG_W-1:0]      depth_ff;
   logic [CFG_W-1:0]      live_ff;
   logic [CFG_W-1:0]      live_in;
   logic [TRACK_BITS-1:0] head_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_kind_ff;
   logic [REQ_W-1:0]      rsp_req_ff;
   logic [TRACK_BITS-1:0] rsp_track_ff;
   logic                  rsp_last_ff;

   q_cmd_type  q_cmd;
   q_stat_type q_stat;

   logic             out_free;
   logic             rsp_load;
   logic [CMP_W-1:0] limit_now;
   logic [CMP_W-1:0] limit_next;
   logic [CMP_W-1:0] count_now;
   logic [CMP_W-1:0] count_plus;
   logic [CMP_W-1:0] count_less;
   logic             reject;
   logic             go_scan;
   logic             more_service;

   function automatic logic [CMP_W-1:0] queue_limit(input logic [CFG_W-1:0] depth,
                                                    input logic [CFG_W-1:0] live);
      logic [CMP_W-1:0] lim;
      lim = CMP_W'(depth);
      if (CMP_W'(live) < lim) begin
         lim = CMP_W'(live);
      end
      if (CMP_W'(QUEUE_DEPTH) < lim) begin
         lim = CMP_W'(QUEUE_DEPTH);
      end
      return lim;
   endfunction

   sstf_entry_queue u_queue (
      .clock (clock),
      .reset (reset),
      .cmd   (q_cmd),
      .stat  (q_stat)
   );

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_chan.ready;
      count_now  = CMP_W'(q_stat.count);
      count_plus = count_now + CMP_W'(1);
      count_less = count_now - CMP_W'(1);
      limit_now  = queue_limit(depth_ff, live_ff);
      // a zero limit takes the request and services it at once
      reject     = q_stat.dup || !q_stat.slot_found ||
                   ((count_now >= limit_now) && (limit_now != '0));
      go_scan    = count_plus >= limit_now;

      live_in = live_ff;
      if (q_stat.best_last && (live_ff != '0)) begin
         live_in = live_ff - CFG_W'(1);
      end
      limit_next   = queue_limit(depth_ff, live_in);
      more_service = (count_less != '0) && (count_less >= limit_next);

      rsp_load = out_free &&
                 (((state_ff == ST_EVAL) && reject) || (state_ff == ST_SERVE));

      q_cmd.insert     = (state_ff == ST_EVAL) && !reject;
      q_cmd.ins_req    = in_req_ff;
      q_cmd.ins_track  = in_track_ff;
      q_cmd.ins_last   = in_last_ff;
      q_cmd.retire     = (state_ff == ST_SERVE) && out_free;
      q_cmd.scan_start = (q_cmd.insert && go_scan) || (q_cmd.retire && more_service);
      q_cmd.head_track = head_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         depth_ff     <= MAX_DEPTH_RESET;
         live_ff      <= NUM_REQ_RESET;
         head_ff      <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_QUEUE_DEPTH: depth_ff <= csr_wdata;
               CSR_NUM_REQUESTERS:  live_ff  <= csr_wdata;
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  in_req_ff   <= req_chan.requester_id;
                  in_track_ff <= req_chan.track;
                  in_last_ff  <= req_chan.final_request;
                  state_ff    <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               if (reject) begin
                  if (out_free) begin
                     rsp_kind_ff  <= RESULT_REJECTED;
                     rsp_req_ff   <= in_req_ff;
                     rsp_track_ff <= in_track_ff;
                     rsp_last_ff  <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
               end else if (go_scan) begin
                  state_ff <= ST_SCAN;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_SCAN: begin
               if (q_stat.scan_done) begin
                  state_ff <= ST_SERVE;
               end
            end
            ST_SERVE: begin
               // hold the winner until the output register frees up
               if (out_free) begin
                  rsp_kind_ff  <= RESULT_SERVICED;
                  rsp_req_ff   <= q_stat.best_requester;
                  rsp_track_ff <= q_stat.best_track;
                  rsp_last_ff  <= !more_service;
                  head_ff      <= q_stat.best_track;
                  live_ff      <= live_in;
                  state_ff     <= more_service ? ST_SCAN : ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_chan.ready            = (state_ff == ST_IDLE);
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.result_kind      = rsp_kind_ff;
   assign rsp_chan.served_requester = rsp_req_ff;
   assign rsp_chan.served_track     = rsp_track_ff;
   assign rsp_chan.last_of_run      = rsp_last_ff;

   a_beat_to_eval: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == ST_EVAL))
      else $error("accepted beat did not move control to evaluation");

   a_scan_finds_entry: assert property (@(posedge clock) disable iff (reset)
      q_stat.scan_done |-> ((state_ff == ST_SCAN) && q_stat.best_found))
      else $error("scan finished outside scan state or without a valid entry");

   a_head_follows_service: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SERVE) && out_free) |=>
         (rsp_valid_ff && (rsp_kind_ff == RESULT_SERVICED) && (head_ff == rsp_track_ff)))
      else $error("head track does not match the serviced request");

endmodule

`default_nettype wire

// ===== hdl/sstf_entry_queue.sv =====
// Pending-request store: entry memory, valid/age/pending bits and the nearest-track scan.
// Depends on sstf_pkg.
`default_nettype none

module sstf_entry_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sstf_pkg::q_cmd_type cmd,
   output sstf_pkg::q_stat_type    stat
);
   import sstf_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_data_ff;

   logic [QUEUE_DEPTH-1:0]    valid_ff, valid_in;
   logic [MAX_REQUESTERS-1:0] pending_ff, pending_in;
   logic [IDX_W-1:0]          age_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0]          age_in [QUEUE_DEPTH];
   logic [COUNT_W-1:0]        count_ff, count_in;

   logic [IDX_W-1:0] slot;
   logic             slot_found;

   logic                  scan_active_ff;
   logic [IDX_W-1:0]      rd_addr_ff;
   logic                  s1_vld_ff;
   logic [IDX_W-1:0]      s1_idx_ff;
   logic                  s2_vld_ff;
   logic                  s2_last_ff;
   logic                  s2_ok_ff;
   logic [IDX_W-1:0]      s2_idx_ff;
   logic [IDX_W-1:0]      s2_age_ff;
   entry_type             s2_entry_ff;
   logic [TRACK_BITS-1:0] s2_dist_ff;
   logic [TRACK_BITS-1:0] seek_gap;
   logic                  better;
   logic                  best_found_ff;
   logic [IDX_W-1:0]      best_idx_ff;
   logic [IDX_W-1:0]      best_age_ff;
   entry_type             best_entry_ff;
   logic [TRACK_BITS-1:0] best_dist_ff;
   logic                  scan_done_ff;

   // lowest free entry
   always_comb begin
      slot       = '0;
      slot_found = 1'b0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            slot       = IDX_W'(i);
            slot_found = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         mem[slot] <= '{requester: cmd.ins_req, track: cmd.ins_track,
                        last_req: cmd.ins_last};
      end
      rd_data_ff <= mem[rd_addr_ff];
   end

   always_comb begin
      valid_in   = valid_ff;
      pending_in = pending_ff;
      count_in   = count_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         age_in[i] = age_ff[i];
      end
      if (cmd.insert) begin
         valid_in[slot]            = 1'b1;
         pending_in[cmd.ins_req]   = 1'b1;
         age_in[slot]              = count_ff[IDX_W-1:0];
         count_in                  = count_ff + COUNT_W'(1);
      end
      if (cmd.retire) begin
         valid_in[best_idx_ff]              = 1'b0;
         pending_in[best_entry_ff.requester] = 1'b0;
         count_in                            = count_ff - COUNT_W'(1);
         // close the gap in arrival rank left by the retired entry
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (valid_ff[i] && (age_ff[i] > best_age_ff)) begin
               age_in[i] = age_ff[i] - IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         pending_ff <= '0;
         count_ff   <= '0;
      end else begin
         valid_ff   <= valid_in;
         pending_ff <= pending_in;
         count_ff   <= count_in;
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         age_ff[i] <= age_in[i];
      end
   end

   always_comb begin
      if (rd_data_ff.track >= cmd.head_track) begin
         seek_gap = rd_data_ff.track - cmd.head_track;
      end else begin
         seek_gap = cmd.head_track - rd_data_ff.track;
      end
      better = !best_found_ff || (s2_dist_ff < best_dist_ff) ||
               ((s2_dist_ff == best_dist_ff) && (s2_age_ff < best_age_ff));
   end

   // scan: read address, distance stage, compare stage
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_active_ff <= 1'b0;
         rd_addr_ff     <= '0;
         s1_vld_ff      <= 1'b0;
         s2_vld_ff      <= 1'b0;
         s2_last_ff     <= 1'b0;
         scan_done_ff   <= 1'b0;
         best_found_ff  <= 1'b0;
      end else begin
         s1_vld_ff    <= scan_active_ff;
         s2_vld_ff    <= s1_vld_ff;
         s2_last_ff   <= s1_vld_ff && (s1_idx_ff == LAST_IDX);
         scan_done_ff <= s2_vld_ff && s2_last_ff;
         if (cmd.scan_start) begin
            scan_active_ff <= 1'b1;
            rd_addr_ff     <= '0;
            best_found_ff  <= 1'b0;
         end else begin
            if (scan_active_ff) begin
               rd_addr_ff <= rd_addr_ff + IDX_W'(1);
               if (rd_addr_ff == LAST_IDX) begin
                  scan_active_ff <= 1'b0;
               end
            end
            if (s2_vld_ff && s2_ok_ff && better) begin
               best_found_ff <= 1'b1;
            end
         end
      end
      s1_idx_ff   <= rd_addr_ff;
      s2_idx_ff   <= s1_idx_ff;
      s2_ok_ff    <= valid_ff[s1_idx_ff];
      s2_age_ff   <= age_ff[s1_idx_ff];
      s2_entry_ff <= rd_data_ff;
      s2_dist_ff  <= seek_gap;
      if (s2_vld_ff && s2_ok_ff && better) begin
         best_idx_ff   <= s2_idx_ff;
         best_age_ff   <= s2_age_ff;
         best_entry_ff <= s2_entry_ff;
         best_dist_ff  <= s2_dist_ff;
      end
   end

   assign stat.dup            = pending_ff[cmd.ins_req];
   assign stat.slot_found     = slot_found;
   assign stat.count          = count_ff;
   assign stat.scan_done      = scan_done_ff;
   assign stat.best_found     = best_found_ff;
   assign stat.best_requester = best_entry_ff.requester;
   assign stat.best_track     = best_entry_ff.track;
   assign stat.best_last      = best_entry_ff.last_req;

endmodule

`default_nettype wire

// ===== bench/tb_sstf_disk_request_scheduler_core.sv =====
// Self-checking bench for the shortest-seek-first disk request scheduler core.
// Needs sstf_pkg, sstf_req_if, sstf_rsp_if and the core; predicts every result
// in-line and checks each response beat in order.
`default_nettype none

module tb_sstf_disk_request_scheduler_core;
   timeunit 1ns;
   timeprecision 1ps;

   import sstf_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned SETTLE      = 40;
   localparam int unsigned RAND_PHASES = 8;
   localparam int unsigned PHASE_ITEMS = 48;

   typedef struct packed {
      logic [REQ_W-1:0]      id;
      logic [TRACK_BITS-1:0] track;
      logic                  fin;
   } disk_request_type;

   typedef struct packed {
      logic                  kind;
      logic [REQ_W-1:0]      requester;
      logic [TRACK_BITS-1:0] track;
      logic                  last_of_run;
   } disk_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CFG_W-1:0]      csr_wdata;

   sstf_req_if req_bus ();
   sstf_rsp_if rsp_bus ();

   sstf_disk_request_scheduler_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Scheduler shadow state
   logic                  slot_busy [QUEUE_DEPTH];
   entry_type             slot_data [QUEUE_DEPTH];
   int unsigned           slot_rank [QUEUE_DEPTH];
   logic [TRACK_BITS-1:0] head_pos;
   int unsigned           depth_cfg;
   int unsigned           live_cnt;

   disk_request_type pending_requests [$];
   disk_result_type  awaited_results [$];
   disk_request_type req_now;
   disk_result_type  seen;
   disk_result_type  want;

   int unsigned idle_pct;
   int unsigned cycle_cnt;
   int unsigned mismatches;
   int unsigned accepted_cnt;
   int unsigned service_cnt;
   int unsigned reject_cnt;
   int unsigned setting_cnt;

   function automatic int unsigned pending_entries();
      int unsigned n;
      n = 0;
      for (int i = 0; i < QUEUE_DEPTH; i++) if (slot_busy[i]) n++;
      return n;
   endfunction

   function automatic int unsigned queue_limit();
      int unsigned lim;
      lim = depth_cfg;
      if (live_cnt < lim) lim = live_cnt;
      if (QUEUE_DEPTH < lim) lim = QUEUE_DEPTH;
      return lim;
   endfunction

   function automatic logic [TRACK_BITS-1:0] seek_dist(input logic [TRACK_BITS-1:0] trk);
      return (trk >= head_pos) ? trk - head_pos : head_pos - trk;
   endfunction

   // Queue one request (or predict its rejection) and expect every service it sets off, nearest track first.
   function automatic void schedule_request(input disk_request_type rq);
      int unsigned     cnt;
      int unsigned     slot;
      int unsigned     best;
      int unsigned     n;
      int              i;
      logic            dup;
      disk_result_type res;
      disk_result_type run [QUEUE_DEPTH];
      cnt  = 0;
      slot = QUEUE_DEPTH;
      dup  = 1'b0;
      n    = 0;
      for (i = 0; i < QUEUE_DEPTH; i++) begin
         if (slot_busy[i]) begin
            cnt++;
            if (slot_data[i].requester == rq.id) dup = 1'b1;
         end else if (slot == QUEUE_DEPTH) begin
            slot = i;
         end
      end
      // a zero limit lets a fresh request straight through instead of bouncing it
      if ((dup || cnt >= queue_limit() || slot == QUEUE_DEPTH) &&
          !(queue_limit() == 0 && !dup && slot < QUEUE_DEPTH)) begin
         res.kind        = RESULT_REJECTED;
         res.requester   = rq.id;
         res.track       = rq.track;
         res.last_of_run = 1'b1;
         awaited_results = {awaited_results, res};
         reject_cnt++;
         return;
      end
      slot_busy[slot]          = 1'b1;
      slot_data[slot].requester = rq.id;
      slot_data[slot].track    = rq.track;
      slot_data[slot].last_req = rq.fin;
      slot_rank[slot]          = cnt;
      cnt++;
      while (cnt > 0 && cnt >= queue_limit() && n < QUEUE_DEPTH) begin
         best = QUEUE_DEPTH;
         for (i = 0; i < QUEUE_DEPTH; i++) begin
            if (slot_busy[i]) begin
               if (best == QUEUE_DEPTH) begin
                  best = i;
               end else if (seek_dist(slot_data[i].track) < seek_dist(slot_data[best].track) ||
                            (seek_dist(slot_data[i].track) == seek_dist(slot_data[best].track)
                             && slot_rank[i] < slot_rank[best])) begin
                  best = i;
               end
            end
         end
         slot_busy[best] = 1'b0;
         for (i = 0; i < QUEUE_DEPTH; i++)
            if (slot_busy[i] && slot_rank[i] > slot_rank[best]) slot_rank[i]--;
         head_pos = slot_data[best].track;
         // a serviced final request retires its requester and may lower the limit
         if (slot_data[best].last_req && live_cnt > 0) live_cnt--;
         run[n].kind        = RESULT_SERVICED;
         run[n].requester   = slot_data[best].requester;
         run[n].track       = slot_data[best].track;
         run[n].last_of_run = 1'b0;
         n++;
         cnt--;
         service_cnt++;
      end
      for (i = 0; i < n; i++) begin
         res             = run[i];
         res.last_of_run = (i == n - 1);
         awaited_results = {awaited_results, res};
      end
   endfunction

   function automatic void report_mismatch(input string what, input disk_result_type exp_res,
                                           input disk_result_type got);
      mismatches++;
      if (mismatches <= 10)
         $display({"%0t: %s: expected kind %0d req %0d track %0d last %0d, ",
                   "got kind %0d req %0d track %0d last %0d"},
                  $realtime, what, exp_res.kind, exp_res.requester, exp_res.track,
                  exp_res.last_of_run, got.kind, got.requester, got.track, got.last_of_run);
   endfunction

   // Request driver: present the next queued beat, hold it until taken
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            schedule_request(req_now);
            accepted_cnt++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_now = pending_requests[0];
               pending_requests.delete(0);
               req_bus.valid         <= 1'b1;
               req_bus.requester_id  <= req_now.id;
               req_bus.track         <= req_now.track;
               req_bus.final_request <= req_now.fin;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: random back-pressure, check each beat against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.kind        = rsp_bus.result_kind;
            seen.requester   = rsp_bus.served_requester;
            seen.track       = rsp_bus.served_track;
            seen.last_of_run = rsp_bus.last_of_run;
            if (awaited_results.size() == 0) begin
               report_mismatch("unexpected result", '0, seen);
            end else begin
               want = awaited_results[0];
               awaited_results.delete(0);
               if (seen.kind != want.kind || seen.requester != want.requester ||
                   seen.track != want.track || seen.last_of_run != want.last_of_run)
                  report_mismatch("wrong result", want, seen);
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_cnt, awaited_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic write_csr(input csr_index_type idx, input int unsigned val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CFG_W'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MAX_QUEUE_DEPTH) begin
         depth_cfg = val;
      end else begin
         live_cnt = val;
      end
   endtask

   task automatic set_config(input int unsigned depth, input int unsigned nreq);
      write_csr(CSR_MAX_QUEUE_DEPTH, depth);
      write_csr(CSR_NUM_REQUESTERS, nreq);
      setting_cnt++;
   endtask

   task automatic queue_request(input int unsigned id, input int unsigned trk,
                                input logic fin);
      disk_request_type rq;
      rq.id    = REQ_W'(id);
      rq.track = TRACK_BITS'(trk);
      rq.fin   = fin;
      pending_requests = {pending_requests, rq};
   endtask

   // Hold off until every beat is sent and answered, then let a queued-only item settle
   task automatic drain();
      while (pending_requests.size() > 0 || req_bus.valid || awaited_results.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      int unsigned           ph;
      int unsigned           k;
      int unsigned           lo;
      int unsigned           depth_sel;
      int unsigned           nreq_sel;
      int unsigned           sel;
      logic [TRACK_BITS-1:0] base;
      disk_request_type      rq;

      req_bus.valid         = 1'b0;
      req_bus.requester_id  = '0;
      req_bus.track         = '0;
      req_bus.final_request = 1'b0;
      rsp_bus.ready         = 1'b0;
      csr_we                = 1'b0;
      csr_index             = CSR_MAX_QUEUE_DEPTH;
      csr_wdata             = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_busy[i] = 1'b0;
         slot_rank[i] = 0;
         slot_data[i] = '0;
      end
      head_pos     = '0;
      depth_cfg    = MAX_DEPTH_RESET;
      live_cnt     = NUM_REQ_RESET;
      idle_pct     = 20;
      cycle_cnt    = 0;
      mismatches   = 0;
      accepted_cnt = 0;
      service_cnt  = 0;
      reject_cnt   = 0;
      setting_cnt  = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // depth of one: every request goes straight out; field extremes
      set_config(1, 16);
      queue_request(0, 16'h0000, 1'b0);
      queue_request(15, 16'hFFFF, 1'b0);
      queue_request(10, 16'h5555, 1'b0);
      queue_request(5, 16'hAAAA, 1'b1);
      drain();

      // one requester that finishes: live count hits zero, then immediate service
      set_config(16, 1);
      queue_request(3, 100, 1'b1);
      queue_request(7, 200, 1'b0);
      queue_request(7, 300, 1'b1);
      drain();

      // fill to the limit: duplicate bounce, equal-seek tie goes to the oldest
      set_config(4, 16);
      queue_request(1, 310, 1'b0);
      queue_request(2, 290, 1'b0);
      queue_request(3, 5000, 1'b0);
      queue_request(2, 7, 1'b0);
      queue_request(4, 60000, 1'b0);
      queue_request(5, 320, 1'b1);
      queue_request(6, 0, 1'b0);
      drain();

      // shrink the depth under the pending count: queue-full bounces
      set_config(2, 16);
      queue_request(9, 123, 1'b0);
      queue_request(12, 16'hFFFF, 1'b1);
      drain();

      for (ph = 0; ph < RAND_PHASES; ph++) begin
         // keep the new limit above what is still pending so the queue can move
         lo        = pending_entries() + 1;
         depth_sel = (ph % 3 == 0) ? 16 : $urandom_range(16, lo);
         nreq_sel  = (ph % 3 == 1) ? 16 : $urandom_range(16, lo);
         idle_pct  = (ph == 3) ? 0 : 20;
         set_config(depth_sel, nreq_sel);
         base = TRACK_BITS'($urandom);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            sel = $urandom_range(99);
            rq.id = (sel < 70) ? REQ_W'($urandom_range(nreq_sel - 1))
                               : REQ_W'($urandom_range(MAX_REQUESTERS - 1));
            sel = $urandom_range(99);
            if (sel < 50) begin
               rq.track = TRACK_BITS'($urandom);
            end else if (sel < 85) begin
               // cluster around a moving base so equal seek distances turn up
               rq.track = base + TRACK_BITS'($urandom_range(16)) - TRACK_BITS'(8);
            end else begin
               rq.track = $urandom_range(1) ? '1 : '0;
            end
            if ($urandom_range(99) < 10) base = TRACK_BITS'($urandom);
            rq.fin = ($urandom_range(99) < 12);
            pending_requests = {pending_requests, rq};
         end
         drain();
      end

      $display("Ran %0d requests over %0d register settings", accepted_cnt, setting_cnt);
      $display("Checked %0d services and %0d rejections", service_cnt, reject_cnt);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
